/* sv/tw_pkg.sv */
`timescale 1ns / 1ps

package tw_pkg;

	localparam int FB = 30;
	localparam logic [30:0] QONE = 31'h4000_0000;
	localparam logic [61:0] QHALF = 62'h0000_0000_2000_0000;
	localparam logic [46:0] WMAX = 47'h7FFF_FFFF_FFFF;
	localparam logic [31:0] THIRD_RECIP = 32'hAAAA_AAAB;

	localparam int DIV_NW = 64;
	localparam int DIV_VW = 36;

	localparam int QDEPTH = 4;

	typedef enum logic [1:0] {
		KIND_SKIP = 2'b00,
		KIND_MISS = 2'b01,
		KIND_ADD  = 2'b10
	} kind_t;

	typedef struct packed {
		logic [9:0]  idx;
		kind_t       kind;
		logic [46:0] contrib;
	} acc_item_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

endpackage

/* sv/tetrahedron_weight_accumulator.sv */
// An item that adds to the store passes up to eight 64-step radix-2 divisions when omega lies
// in the middle interval and up to seven otherwise before its result goes to the queue.
// An item with an index beyond the store or an omega outside the span skips the divisions.
// The front takes the next item only once the last is in the queue; the back runs on its own.
// Reset is asynchronous; afterwards full stays high while the
// weight store is cleared one entry per cycle.
`timescale 1ns / 1ps

module tetrahedron_weight_accumulator #(
	parameter int FREQ_COUNT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] corner_energy_0,
	input  logic signed [31:0] corner_energy_1,
	input  logic signed [31:0] corner_energy_2,
	input  logic signed [31:0] corner_energy_3,
	input  logic signed [31:0] reference_energy,
	input  logic [31:0]        tetra_volume,
	input  logic signed [31:0] frequency_value,
	input  logic [9:0]         frequency_index,
	output logic               empty,
	input  logic               pop,
	output logic signed [47:0] accumulated_weight,
	output logic               contributed
);
	import tw_pkg::*;

	acc_item_t  f_item;
	acc_item_t  b_item;
	logic       f_push;
	logic       q_full;
	logic       q_empty;
	logic       b_pop;
	back_stat_t stat;

	tw_front #(
		.FREQ_COUNT (FREQ_COUNT)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.corner_energy_0  (corner_energy_0),
		.corner_energy_1  (corner_energy_1),
		.corner_energy_2  (corner_energy_2),
		.corner_energy_3  (corner_energy_3),
		.reference_energy (reference_energy),
		.tetra_volume     (tetra_volume),
		.frequency_value  (frequency_value),
		.frequency_index  (frequency_index),
		.stat             (stat),
		.q_push           (f_push),
		.q_item           (f_item),
		.q_full           (q_full)
	);

	tw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push),
		.item_in  (f_item),
		.full     (q_full),
		.pop      (b_pop),
		.item_out (b_item),
		.empty    (q_empty)
	);

	tw_back #(
		.FREQ_COUNT (FREQ_COUNT)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.q_item             (b_item),
		.q_empty            (q_empty),
		.q_pop              (b_pop),
		.stat               (stat),
		.empty              (empty),
		.pop                (pop),
		.accumulated_weight (accumulated_weight),
		.contributed        (contributed)
	);

endmodule

/* sv/tw_div.sv */
`timescale 1ns / 1ps

module tw_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tw_pkg::DIV_NW-1:0]  dividend,
	input  logic [tw_pkg::DIV_VW-1:0]  divisor,
	output logic                       done,
	output logic [tw_pkg::DIV_NW-1:0]  quotient
);
	import tw_pkg::*;

	localparam int CW = $clog2(DIV_NW + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DIV_VW-1:0] rem_q;
	logic [DIV_VW-1:0] dsr_q;
	logic [DIV_NW-1:0] quo_q;

	logic [DIV_VW:0]   trial;
	logic [DIV_VW:0]   diff;
	logic              ge;

	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* sv/tw_queue.sv */
`timescale 1ns / 1ps

module tw_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tw_pkg::acc_item_t item_in,
	output logic              full,
	input  logic              pop,
	output tw_pkg::acc_item_t item_out,
	output logic              empty
);
	import tw_pkg::*;

	localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	acc_item_t      slot_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full     = cnt_q == (QAW + 1)'(QDEPTH);
	assign empty    = cnt_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign item_out = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QAW'(QDEPTH - 1)) ? '0 : wr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == QAW'(QDEPTH - 1)) ? '0 : rd_q + QAW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (QAW + 1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (QAW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= item_in;
		end
	end

endmodule

/* sv/tw_front.sv */
`timescale 1ns / 1ps

module tw_front #(
	parameter int FREQ_COUNT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] corner_energy_0,
	input  logic signed [31:0] corner_energy_1,
	input  logic signed [31:0] corner_energy_2,
	input  logic signed [31:0] corner_energy_3,
	input  logic signed [31:0] reference_energy,
	input  logic [31:0]        tetra_volume,
	input  logic signed [31:0] frequency_value,
	input  logic [9:0]         frequency_index,
	input  tw_pkg::back_stat_t stat,
	output logic               q_push,
	output tw_pkg::acc_item_t  q_item,
	input  logic               q_full
);
	import tw_pkg::*;

	typedef enum logic [21:0] {
		ST_IDLE  = 22'h000001,
		ST_SORT  = 22'h000002,
		ST_CLASS = 22'h000004,
		ST_FDIV  = 22'h000008,
		ST_FWAIT = 22'h000010,
		ST_N1    = 22'h000020,
		ST_N2    = 22'h000040,
		ST_N3    = 22'h000080,
		ST_X1    = 22'h000100,
		ST_X2    = 22'h000200,
		ST_X3    = 22'h000400,
		ST_T1    = 22'h000800,
		ST_T2    = 22'h001000,
		ST_QDIV  = 22'h002000,
		ST_QWAIT = 22'h004000,
		ST_CLAMP = 22'h008000,
		ST_A1    = 22'h010000,
		ST_A2    = 22'h020000,
		ST_P     = 22'h040000,
		ST_CDIV  = 22'h080000,
		ST_CWAIT = 22'h100000,
		ST_PUSH  = 22'h200000
	} state_t;

	typedef enum logic [1:0] {
		REG_NONE = 2'd0,
		REG_LOW  = 2'd1,
		REG_MID  = 2'd2,
		REG_HIGH = 2'd3
	} region_t;

	state_t             state_q;
	logic signed [31:0] e_q [4];
	logic signed [31:0] ek_q;
	logic [31:0]        vol_q;
	logic signed [31:0] w_q;
	logic [9:0]         idx_q;
	logic signed [31:0] s_q [4];
	logic [2:0]         rank_q;
	region_t            region_q;
	kind_t              kind_q;
	logic [2:0]         k_q;
	logic               fzero_q;
	logic [30:0]        frac_q [6];
	logic [65:0]        prod_q;
	logic [60:0]        nsum_q;
	logic [31:0]        n_q;
	logic [33:0]        n3_q;
	logic [30:0]        x_q;
	logic [31:0]        t_q;
	logic [63:0]        q_q;
	logic [30:0]        ival_q;
	logic [30:0]        a_q;
	logic [46:0]        c_q;

	logic signed [31:0] l1 [4];
	logic signed [31:0] l2 [4];
	logic signed [31:0] srt [4];
	logic [3:0]         lt;
	logic [2:0]         rank_d;
	logic               r1, r2, r3;
	logic               idx_ok;

	logic [30:0] f10, f20, f30, f21, f31, f32;
	logic [30:0] f01, f02, f03, f12, f13, f23;

	logic signed [31:0] base, tip;
	logic signed [32:0] num, den;
	logic [31:0]        den32, num_c;
	logic [63:0]        frac_dvd;

	logic [31:0]        dsel;
	logic [35:0]        dd;

	logic               div_start;
	logic [63:0]        div_dvd;
	logic [35:0]        div_dsr;
	logic               div_done;
	logic [63:0]        div_quo;

	logic               mul_en;
	logic [31:0]        mul_a;
	logic [33:0]        mul_b;
	logic [65:0]        mul_p;
	logic [61:0]        rnd_sum;
	logic [30:0]        rnd;
	logic [31:0]        y;
	logic [61:0]        n_sum;
	logic [64:0]        ival_sum;
	logic [63:0]        a_sum;

	assign full   = (state_q != ST_IDLE) || stat.clearing;
	assign idx_ok = {7'b0, idx_q} < 17'(FREQ_COUNT);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			lt[i] = e_q[i] < ek_q;
		end
		rank_d = 3'(lt[0]) + 3'(lt[1]) + 3'(lt[2]) + 3'(lt[3]);
		l1[0] = (e_q[0] < e_q[1]) ? e_q[0] : e_q[1];
		l1[1] = (e_q[0] < e_q[1]) ? e_q[1] : e_q[0];
		l1[2] = (e_q[2] < e_q[3]) ? e_q[2] : e_q[3];
		l1[3] = (e_q[2] < e_q[3]) ? e_q[3] : e_q[2];
		l2[0] = (l1[0] < l1[2]) ? l1[0] : l1[2];
		l2[2] = (l1[0] < l1[2]) ? l1[2] : l1[0];
		l2[1] = (l1[1] < l1[3]) ? l1[1] : l1[3];
		l2[3] = (l1[1] < l1[3]) ? l1[3] : l1[1];
		srt[0] = l2[0];
		srt[3] = l2[3];
		srt[1] = (l2[1] < l2[2]) ? l2[1] : l2[2];
		srt[2] = (l2[1] < l2[2]) ? l2[2] : l2[1];
	end

	assign r1 = (s_q[1] != s_q[0]) && (s_q[0] <= w_q) && (w_q <= s_q[1]);
	assign r2 = (s_q[1] != s_q[2]) && (s_q[1] < w_q) && (w_q < s_q[2]);
	assign r3 = (s_q[2] != s_q[3]) && (s_q[2] <= w_q) && (w_q <= s_q[3]);

	assign f10 = frac_q[0];
	assign f20 = frac_q[1];
	assign f30 = frac_q[2];
	assign f21 = frac_q[3];
	assign f31 = frac_q[4];
	assign f32 = frac_q[5];
	assign f01 = QONE - f10;
	assign f02 = QONE - f20;
	assign f03 = QONE - f30;
	assign f12 = QONE - f21;
	assign f13 = QONE - f31;
	assign f23 = QONE - f32;

	always_comb begin
		case (k_q)
			3'd0: begin base = s_q[0]; tip = s_q[1]; end
			3'd1: begin base = s_q[0]; tip = s_q[2]; end
			3'd2: begin base = s_q[0]; tip = s_q[3]; end
			3'd3: begin base = s_q[1]; tip = s_q[2]; end
			3'd4: begin base = s_q[1]; tip = s_q[3]; end
			default: begin base = s_q[2]; tip = s_q[3]; end
		endcase
		num   = {w_q[31], w_q} - {base[31], base};
		den   = {tip[31], tip} - {base[31], base};
		den32 = den[31:0];
		if (num[32]) begin
			num_c = '0;
		end else if (num[31:0] > den32) begin
			num_c = den32;
		end else begin
			num_c = num[31:0];
		end
		frac_dvd = {2'b0, num_c, 30'b0} + {33'b0, den32[31:1]};
	end

	always_comb begin
		unique case (region_q)
			REG_LOW: dsel = 32'(s_q[1] - s_q[0]);
			REG_MID: dsel = 32'(s_q[3] - s_q[0]);
			REG_HIGH: dsel = 32'(s_q[3] - s_q[2]);
			default: dsel = '0;
		endcase
		dd = {dsel, 4'b0};
	end

	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dsr   = '0;
		if (state_q == ST_FDIV) begin
			div_start = 1'b1;
			div_dvd   = frac_dvd;
			div_dsr   = {4'b0, den32};
		end else if (state_q == ST_QDIV) begin
			div_start = (region_q == REG_MID) && (n3_q != '0);
			div_dvd   = {3'b0, x_q, 30'b0} + {31'b0, n3_q[33:1]};
			div_dsr   = {2'b0, n3_q};
		end else if (state_q == ST_CDIV) begin
			div_start = dd != '0;
			div_dvd   = prod_q[63:0] + {29'b0, dd[35:1]};
			div_dsr   = dd;
		end
	end

	tw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign rnd_sum = prod_q[61:0] + QHALF;
	assign rnd     = rnd_sum[60:30];

	always_comb begin
		unique case (region_q)
			REG_LOW: begin
				case (rank_q)
					3'd0: y = 32'(f01) + 32'(f02) + 32'(f03);
					3'd1: y = 32'(f10);
					3'd2: y = 32'(f20);
					3'd3: y = 32'(f30);
					default: y = '0;
				endcase
			end
			REG_MID: begin
				case (rank_q)
					3'd0: y = 32'(f03);
					3'd1: y = 32'(f12);
					3'd2: y = 32'(f21);
					3'd3: y = 32'(f30);
					default: y = '0;
				endcase
			end
			REG_HIGH: begin
				case (rank_q)
					3'd0: y = 32'(f03);
					3'd1: y = 32'(f13);
					3'd2: y = 32'(f23);
					3'd3: y = 32'(f30) + 32'(f31) + 32'(f32);
					default: y = '0;
				endcase
			end
			default: y = '0;
		endcase
	end

	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			ST_N1: begin
				unique case (region_q)
					REG_LOW: begin mul_a = 32'(f20); mul_b = 34'(f30); end
					REG_MID: begin mul_a = 32'(f12); mul_b = 34'(f20); end
					REG_HIGH: begin mul_a = 32'(f03); mul_b = 34'(f13); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			ST_N2: begin
				mul_a = 32'(f21);
				mul_b = 34'(f13);
			end
			ST_X1: begin
				case (rank_q)
					3'd0: begin mul_a = 32'(f02); mul_b = 34'(f20); end
					3'd1: begin mul_a = 32'(f13); mul_b = 34'(f13); end
					3'd2: begin mul_a = 32'(f20); mul_b = 34'(f20); end
					3'd3: begin mul_a = 32'(f31); mul_b = 34'(f13); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			ST_X2: begin
				mul_a = 32'(rnd);
				case (rank_q)
					3'd0, 3'd2: mul_b = 34'(f12);
					3'd1, 3'd3: mul_b = 34'(f21);
					default: mul_b = '0;
				endcase
			end
			ST_T1: begin
				mul_a = y + 32'd1;
				mul_b = 34'(THIRD_RECIP);
			end
			ST_A1: begin
				mul_a = vol_q;
				mul_b = 34'(ival_q);
			end
			ST_P: begin
				mul_a = 32'(a_q);
				mul_b = n3_q;
			end
			default: mul_en = 1'b0;
		endcase
	end

	assign mul_p    = 66'(mul_a) * 66'(mul_b);
	assign n_sum    = {1'b0, nsum_q} + ((region_q == REG_MID) ? prod_q[61:0] : 62'b0) + QHALF;
	assign ival_sum = {33'b0, t_q} + {1'b0, q_q};
	assign a_sum    = prod_q[63:0] + 64'h0000_0000_8000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (push && !full) state_q <= ST_SORT;
				ST_SORT: state_q <= ST_CLASS;
				ST_CLASS: begin
					if (!idx_ok || !(r1 || r2 || r3)) begin
						state_q <= ST_PUSH;
					end else begin
						state_q <= ST_FDIV;
					end
				end
				ST_FDIV: state_q <= ST_FWAIT;
				ST_FWAIT: begin
					if (div_done) begin
						state_q <= (k_q == 3'd5) ? ST_N1 : ST_FDIV;
					end
				end
				ST_N1: state_q <= ST_N2;
				ST_N2: state_q <= ST_N3;
				ST_N3: state_q <= ST_X1;
				ST_X1: state_q <= ST_X2;
				ST_X2: state_q <= ST_X3;
				ST_X3: state_q <= ST_T1;
				ST_T1: state_q <= ST_T2;
				ST_T2: state_q <= ST_QDIV;
				ST_QDIV: state_q <= div_start ? ST_QWAIT : ST_CLAMP;
				ST_QWAIT: if (div_done) state_q <= ST_CLAMP;
				ST_CLAMP: state_q <= ST_A1;
				ST_A1: state_q <= ST_A2;
				ST_A2: state_q <= ST_P;
				ST_P: state_q <= ST_CDIV;
				ST_CDIV: state_q <= div_start ? ST_CWAIT : ST_PUSH;
				ST_CWAIT: if (div_done) state_q <= ST_PUSH;
				ST_PUSH: if (!q_full) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_p;
		end
		case (state_q)
			ST_IDLE: begin
				e_q[0] <= corner_energy_0;
				e_q[1] <= corner_energy_1;
				e_q[2] <= corner_energy_2;
				e_q[3] <= corner_energy_3;
				ek_q   <= reference_energy;
				vol_q  <= tetra_volume;
				w_q    <= frequency_value;
				idx_q  <= frequency_index;
			end
			ST_SORT: begin
				s_q    <= srt;
				rank_q <= rank_d;
			end
			ST_CLASS: begin
				c_q <= '0;
				k_q <= '0;
				if (r1) region_q <= REG_LOW;
				else if (r2) region_q <= REG_MID;
				else if (r3) region_q <= REG_HIGH;
				else region_q <= REG_NONE;
				if (!idx_ok) kind_q <= KIND_SKIP;
				else if (!(r1 || r2 || r3)) kind_q <= KIND_MISS;
				else kind_q <= KIND_ADD;
			end
			ST_FDIV: fzero_q <= den32 == '0;
			ST_FWAIT: begin
				if (div_done) begin
					frac_q[k_q] <= fzero_q ? 31'b0 : div_quo[30:0];
					k_q         <= k_q + 3'd1;
				end
			end
			ST_N2: nsum_q <= prod_q[60:0];
			ST_N3: n_q <= n_sum[61:30];
			ST_X1: n3_q <= {2'b0, n_q} + {1'b0, n_q, 1'b0};
			ST_X3: x_q <= rnd;
			ST_T2: t_q <= prod_q[64:33];
			ST_QDIV: if (!div_start) q_q <= '0;
			ST_QWAIT: if (div_done) q_q <= div_quo;
			ST_CLAMP: ival_q <= (ival_sum > 65'(QONE)) ? QONE : ival_sum[30:0];
			ST_A2: a_q <= a_sum[62:32];
			ST_CWAIT: begin
				if (div_done) begin
					c_q <= (div_quo > 64'(WMAX)) ? WMAX : div_quo[46:0];
				end
			end
			default: ;
		endcase
	end

	assign q_push       = (state_q == ST_PUSH) && !q_full;
	assign q_item.idx     = idx_q;
	assign q_item.kind    = kind_q;
	assign q_item.contrib = c_q;

endmodule

/* sv/tw_back.sv */
`timescale 1ns / 1ps

module tw_back #(
	parameter int FREQ_COUNT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tw_pkg::acc_item_t  q_item,
	input  logic               q_empty,
	output logic               q_pop,
	output tw_pkg::back_stat_t stat,
	output logic               empty,
	input  logic               pop,
	output logic signed [47:0] accumulated_weight,
	output logic               contributed
);
	import tw_pkg::*;

	localparam int AW = (FREQ_COUNT > 1) ? $clog2(FREQ_COUNT) : 1;

	typedef enum logic [2:0] {
		BS_CLEAR  = 3'b001,
		BS_IDLE   = 3'b010,
		BS_UPDATE = 3'b100
	} bstate_t;

	bstate_t            state_q;
	logic [AW-1:0]      clr_q;
	acc_item_t          item_q;
	logic [47:0]        rd_data_q;
	logic               out_valid_q;
	logic signed [47:0] out_w_q;
	logic               out_c_q;

	logic [47:0]        mem [FREQ_COUNT];
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [47:0]        mem_wd;

	logic signed [48:0] sum;
	logic [47:0]        sat;

	assign q_pop         = (state_q == BS_IDLE) && !q_empty && !out_valid_q;
	assign stat.clearing = state_q == BS_CLEAR;

	assign sum = {rd_data_q[47], rd_data_q} + {2'b0, item_q.contrib};
	assign sat = (sum > $signed({2'b0, WMAX})) ? {1'b0, WMAX} : sum[47:0];

	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_q;
		mem_wd = '0;
		if (state_q == BS_CLEAR) begin
			mem_we = 1'b1;
		end else if (state_q == BS_UPDATE && item_q.kind == KIND_ADD) begin
			mem_we = 1'b1;
			mem_wa = AW'(item_q.idx);
			mem_wd = sat;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (q_pop) begin
			rd_data_q <= mem[AW'(q_item.idx)];
			item_q    <= q_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BS_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				BS_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(FREQ_COUNT - 1)) begin
						state_q <= BS_IDLE;
					end
				end
				BS_IDLE: if (q_pop) state_q <= BS_UPDATE;
				BS_UPDATE: begin
					out_valid_q <= 1'b1;
					state_q     <= BS_IDLE;
				end
				default: state_q <= BS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BS_UPDATE) begin
			unique case (item_q.kind)
				KIND_MISS: begin
					out_w_q <= rd_data_q;
					out_c_q <= 1'b0;
				end
				KIND_ADD: begin
					out_w_q <= sat;
					out_c_q <= 1'b1;
				end
				default: begin
					out_w_q <= '0;
					out_c_q <= 1'b0;
				end
			endcase
		end
	end

	assign empty              = !out_valid_q;
	assign accumulated_weight = out_w_q;
	assign contributed        = out_c_q;

endmodule

/* sv/tw_checker.sv */
`timescale 1ns / 1ps

module tw_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic               empty,
	input logic               pop,
	input logic signed [47:0] accumulated_weight
);

	logic [3:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			if ((push && !full) && !(pop && !empty)) begin
				pend_q <= pend_q + 4'd1;
			end else if (!(push && !full) && (pop && !empty)) begin
				pend_q <= pend_q - 4'd1;
			end
		end
	end

	// The store only ever grows from zero, so a shown weight is never negative.
	a_weight_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !accumulated_weight[47])
		else $error("negative accumulated weight");

	// A result is shown only for an item whose transfer has been taken.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pend_q != 4'd0)
		else $error("result without an accepted item");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result dropped before transfer");

endmodule

bind tetrahedron_weight_accumulator tw_checker u_chk (.*);
